// File: hdl/magic_length_stream_deframer_defines.svh
// Assertion macros shared by the deframer RTL.
`ifndef MAGIC_LENGTH_STREAM_DEFRAMER_DEFINES_SVH
`define MAGIC_LENGTH_STREAM_DEFRAMER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MLSD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("deframer assertion failed");

// Next-cycle implication, checked out of reset.
`define MLSD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("deframer assertion failed");

`endif

// File: hdl/mlsd_pkg.sv
// Constants and codes of the length-prefixed stream deframer.
package mlsd_pkg;

  // Sync pair
  localparam logic [7:0] SyncA = 8'h94;
  localparam logic [7:0] SyncB = 8'hC3;

  // Reset value of the length limit register
  localparam logic [15:0] MaxLenReset = 16'd512;

  // Parser phase codes
  localparam logic [2:0] PhHunt   = 3'd0;
  localparam logic [2:0] PhPrimed = 3'd1;
  localparam logic [2:0] PhLenHi  = 3'd2;
  localparam logic [2:0] PhLenLo  = 3'd3;
  localparam logic [2:0] PhData   = 3'd4;

  // Result kinds carried in tuser
  localparam logic [1:0] KindNone  = 2'd0;
  localparam logic [1:0] KindData  = 2'd1;
  localparam logic [1:0] KindEmpty = 2'd2;

  // Output data word width: payload byte and three 32-bit counters
  localparam int unsigned OutDataW = 104;

endpackage

// File: hdl/magic_length_stream_deframer.sv
// Sync-word and length-prefixed byte stream deframer, top level.
//
// Takes one received byte per beat and gives exactly one result beat per input beat, in the
// cycle after it. The result holds the result kind, the payload byte, a frame-end mark and
// the three running counters. A new byte can enter in every cycle; the input is held off
// only while a result sits in the output register and the downstream side stalls, so the
// rate is one byte per cycle, set by the single parser register stage. The length limit
// is written through the cfg channel, which is always ready, and must only change while
// the stream is idle.
`include "magic_length_stream_deframer_defines.svh"

module magic_length_stream_deframer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Length limit write channel
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [15:0]                   cfg_data_i,   // max_payload_len
  // Byte input
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [7:0]                    s_axis_tdata, // [7:0] rx_byte
  // Result output
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // [7:0] payload_byte, [39:8] good_frames, [71:40] sync_breaks,
  // [103:72] oversize_drops
  output logic [mlsd_pkg::OutDataW-1:0] m_axis_tdata,
  output logic                          m_axis_tlast, // frame_end
  output logic [1:0]                    m_axis_tuser  // out_kind
);

  logic        in_beat;
  logic [15:0] max_len_q;
  logic [2:0]  phase_q, phase_d;
  logic [15:0] len_q, len_d;
  logic [15:0] bytes_q, bytes_d;
  logic [31:0] good_q, good_d;
  logic [31:0] resync_q, resync_d;
  logic [31:0] oversize_q, oversize_d;
  logic [15:0] len_full;
  logic [15:0] bytes_inc;
  logic [1:0]  kind_d;
  logic [7:0]  data_d;
  logic        end_d;
  logic        out_valid_q;
  logic [1:0]  out_kind_q;
  logic [7:0]  out_data_q;
  logic        out_end_q;

  // Take a byte whenever the result register is free or drains this cycle
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_beat       = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Hold the length limit
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= mlsd_pkg::MaxLenReset;
    end else if (cfg_valid_i) begin
      max_len_q <= cfg_data_i;
    end
  end

  assign len_full  = {len_q[15:8], s_axis_tdata};
  assign bytes_inc = bytes_q + 16'd1;

  // Parse one byte
  always_comb begin
    phase_d    = phase_q;
    len_d      = len_q;
    bytes_d    = bytes_q;
    good_d     = good_q;
    resync_d   = resync_q;
    oversize_d = oversize_q;
    kind_d     = mlsd_pkg::KindNone;
    data_d     = 8'h00;
    end_d      = 1'b0;
    unique case (phase_q)
      mlsd_pkg::PhPrimed: begin
        if (s_axis_tdata == mlsd_pkg::SyncB) begin
          phase_d = mlsd_pkg::PhLenHi;
        end else if (s_axis_tdata == mlsd_pkg::SyncA) begin
          phase_d = mlsd_pkg::PhPrimed;
        end else begin
          phase_d  = mlsd_pkg::PhHunt;
          resync_d = resync_q + 32'd1;
        end
      end
      mlsd_pkg::PhLenHi: begin
        len_d   = {s_axis_tdata, 8'h00};
        phase_d = mlsd_pkg::PhLenLo;
      end
      mlsd_pkg::PhLenLo: begin
        len_d   = len_full;
        bytes_d = 16'd0;
        if (len_full == 16'd0) begin
          kind_d  = mlsd_pkg::KindEmpty;
          end_d   = 1'b1;
          good_d  = good_q + 32'd1;
          phase_d = mlsd_pkg::PhHunt;
        end else if (len_full > max_len_q) begin
          oversize_d = oversize_q + 32'd1;
          phase_d    = mlsd_pkg::PhHunt;
        end else begin
          phase_d = mlsd_pkg::PhData;
        end
      end
      mlsd_pkg::PhData: begin
        kind_d  = mlsd_pkg::KindData;
        data_d  = s_axis_tdata;
        bytes_d = bytes_inc;
        if (bytes_inc >= len_q) begin
          end_d   = 1'b1;
          good_d  = good_q + 32'd1;
          phase_d = mlsd_pkg::PhHunt;
        end
      end
      default: begin
        phase_d = (s_axis_tdata == mlsd_pkg::SyncA) ? mlsd_pkg::PhPrimed
                                                    : mlsd_pkg::PhHunt;
      end
    endcase
  end

  // Advance parser state and counters on each input beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= mlsd_pkg::PhHunt;
      len_q      <= 16'd0;
      bytes_q    <= 16'd0;
      good_q     <= 32'd0;
      resync_q   <= 32'd0;
      oversize_q <= 32'd0;
    end else if (in_beat) begin
      phase_q    <= phase_d;
      len_q      <= len_d;
      bytes_q    <= bytes_d;
      good_q     <= good_d;
      resync_q   <= resync_d;
      oversize_q <= oversize_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  // Load the result payload
  always_ff @(posedge clk_i) begin
    if (in_beat) begin
      out_kind_q <= kind_d;
      out_data_q <= data_d;
      out_end_q  <= end_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_end_q;
  assign m_axis_tdata  = {oversize_q, resync_q, good_q, out_data_q};

  `MLSD_ASSERT_NOW(a_none_no_end,
    m_axis_tvalid && m_axis_tuser == mlsd_pkg::KindNone, !m_axis_tlast)
  `MLSD_ASSERT_NOW(a_empty_ends,
    m_axis_tvalid && m_axis_tuser == mlsd_pkg::KindEmpty,
    m_axis_tlast && m_axis_tdata[7:0] == 8'h00)
  `MLSD_ASSERT_NOW(a_data_below_len,
    phase_q == mlsd_pkg::PhData, bytes_q < len_q)
  `MLSD_ASSERT_NEXT(a_len_hi_to_lo,
    in_beat && phase_q == mlsd_pkg::PhLenHi, phase_q == mlsd_pkg::PhLenLo)
  `MLSD_ASSERT_NEXT(a_hunt_exit,
    in_beat && phase_q == mlsd_pkg::PhHunt,
    phase_q == mlsd_pkg::PhHunt || phase_q == mlsd_pkg::PhPrimed)

endmodule
